/* rtl/core/lfu_pkg.sv */
// lfu_pkg: shared widths, defaults and reset values for the lfu cache table
// no dependencies; used by the interfaces, the cells and the top level
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CAP_W  = 5;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/lfu_if.sv */
// lfu_req_if and lfu_rsp_if: valid/ready channels for requests and results
// depends on lfu_pkg for field widths
`default_nettype none

interface lfu_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic        [lfu_pkg::KEY_W-1:0]  key;
    logic signed [lfu_pkg::DATA_W-1:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [lfu_pkg::DATA_W-1:0] read_value;
    logic                              evicted;

    modport source (output valid, output hit, output read_value, output evicted, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

`default_nettype wire

/* rtl/core/lfu_cell.sv */
// lfu_cell: one cache entry plus one stage of the scan token chain
// depends on lfu_pkg; instantiated in a row by lfu_cache_table
`default_nettype none

module lfu_cell #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    parameter int CELL_IDX   = 0,
    localparam int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [lfu_pkg::KEY_W-1:0]   i_key,
    // token from the left neighbor
    input  wire                        i_found,
    input  wire [IW-1:0]               i_fidx,
    input  wire [lfu_pkg::DATA_W-1:0]  i_fdata,
    input  wire [IW-1:0]               i_frank,
    input  wire                        i_vhas,
    input  wire [IW-1:0]               i_vidx,
    input  wire [COUNT_BITS-1:0]       i_vcnt,
    input  wire [IW-1:0]               i_vrank,
    input  wire                        i_freehas,
    input  wire [IW-1:0]               i_freeidx,
    // token to the right neighbor
    output logic                       o_found,
    output logic [IW-1:0]              o_fidx,
    output logic [lfu_pkg::DATA_W-1:0] o_fdata,
    output logic [IW-1:0]              o_frank,
    output logic                       o_vhas,
    output logic [IW-1:0]              o_vidx,
    output logic [COUNT_BITS-1:0]      o_vcnt,
    output logic [IW-1:0]              o_vrank,
    output logic                       o_freehas,
    output logic [IW-1:0]              o_freeidx,
    // broadcast update
    input  wire                        i_upd_hit,
    input  wire                        i_upd_ins,
    input  wire                        i_put,
    input  wire [lfu_pkg::DATA_W-1:0]  i_value,
    input  wire [IW-1:0]               i_hit_idx,
    input  wire [IW-1:0]               i_hit_rank,
    input  wire                        i_evict,
    input  wire [IW-1:0]               i_vic_idx,
    input  wire [IW-1:0]               i_vic_rank,
    input  wire [IW-1:0]               i_ins_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic                      r_valid;
    logic [lfu_pkg::KEY_W-1:0] r_key;
    logic [lfu_pkg::DATA_W-1:0] r_data;
    logic [COUNT_BITS-1:0]     r_cnt;
    logic [IW-1:0]             r_rank;

    logic match, take_vic, take_free;

    assign match     = r_valid && (r_key == i_key) && !i_found;
    assign take_vic  = r_valid && (!i_vhas || (r_cnt < i_vcnt) ||
                       ((r_cnt == i_vcnt) && (r_rank > i_vrank)));
    assign take_free = !r_valid && !i_freehas;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_found   <= 1'b0;
            o_vhas    <= 1'b0;
            o_freehas <= 1'b0;
        end else begin
            o_found   <= i_found | match;
            o_vhas    <= i_vhas | take_vic;
            o_freehas <= i_freehas | take_free;
        end
        o_fidx    <= match ? MY_IDX : i_fidx;
        o_fdata   <= match ? r_data : i_fdata;
        o_frank   <= match ? r_rank : i_frank;
        o_vidx    <= take_vic ? MY_IDX : i_vidx;
        o_vcnt    <= take_vic ? r_cnt : i_vcnt;
        o_vrank   <= take_vic ? r_rank : i_vrank;
        o_freeidx <= take_free ? MY_IDX : i_freeidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd_hit) begin
            if (i_hit_idx == MY_IDX) begin
                r_rank <= '0;
                if (r_cnt != {COUNT_BITS{1'b1}}) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (i_put) begin
                    r_data <= i_value;
                end
            end else if (r_valid && (r_rank < i_hit_rank)) begin
                r_rank <= r_rank + 1'b1;
            end
        end else if (i_upd_ins) begin
            if (i_ins_idx == MY_IDX) begin
                r_valid <= 1'b1;
                r_key   <= i_key;
                r_data  <= i_value;
                r_cnt   <= COUNT_BITS'(1);
                r_rank  <= '0;
            end else if (i_evict && (i_vic_idx == MY_IDX)) begin
                r_valid <= 1'b0;
            end else if (r_valid) begin
                // close the victim's rank gap, then age behind the new entry
                if (i_evict && (r_rank > i_vic_rank)) begin
                    r_rank <= r_rank;
                end else begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lfu_cache_table.sv */
// lfu_cache_table: least-frequently-used cache, lru order breaks count ties
// sequence: accept, scan while the token walks the cell row, then an update state that
// waits for room in the result register; no new request is taken until the update is done
// reset: entries invalid, occupancy zero, capacity 16; no clearing pass
// depends on lfu_pkg, lfu_if and lfu_cell
`default_nettype none

module lfu_cache_table #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [lfu_pkg::CAP_W-1:0]  i_cfg_data,
    lfu_req_if.sink                   i_req,
    lfu_rsp_if.source                 o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > lfu_pkg::CAP_W) ? OW : lfu_pkg::CAP_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [IW-1:0]              r_scan_cnt;
    logic [lfu_pkg::CAP_W-1:0]  r_cap;
    logic [OW-1:0]              r_occ;

    // captured request
    logic                       r_put;
    logic [lfu_pkg::KEY_W-1:0]  r_key;
    logic [lfu_pkg::DATA_W-1:0] r_value;

    // result register
    logic                       r_out_valid;
    logic                       r_out_hit;
    logic [lfu_pkg::DATA_W-1:0] r_out_value;
    logic                       r_out_evicted;

    // token chain, slot k feeds cell k
    logic                       tk_found   [ENTRIES+1];
    logic [IW-1:0]              tk_fidx    [ENTRIES+1];
    logic [lfu_pkg::DATA_W-1:0] tk_fdata   [ENTRIES+1];
    logic [IW-1:0]              tk_frank   [ENTRIES+1];
    logic                       tk_vhas    [ENTRIES+1];
    logic [IW-1:0]              tk_vidx    [ENTRIES+1];
    logic [COUNT_BITS-1:0]      tk_vcnt    [ENTRIES+1];
    logic [IW-1:0]              tk_vrank   [ENTRIES+1];
    logic                       tk_freehas [ENTRIES+1];
    logic [IW-1:0]              tk_freeidx [ENTRIES+1];

    // empty token enters at the left end
    assign tk_found[0]   = 1'b0;
    assign tk_fidx[0]    = '0;
    assign tk_fdata[0]   = '0;
    assign tk_frank[0]   = '0;
    assign tk_vhas[0]    = 1'b0;
    assign tk_vidx[0]    = '0;
    assign tk_vcnt[0]    = '0;
    assign tk_vrank[0]   = '0;
    assign tk_freehas[0] = 1'b0;
    assign tk_freeidx[0] = '0;

    logic          accept, can_load, upd_fire;
    logic [CW-1:0] cap_ext, cap_eff;
    logic          cap_zero, found, evict, ins, upd_hit;
    logic [IW-1:0] ins_idx;

    assign accept   = i_req.valid && i_req.ready;
    assign can_load = !r_out_valid || o_rsp.ready;
    assign upd_fire = (r_state == ST_UPD) && can_load;

    // capacity above the table size acts as the table size
    assign cap_ext  = CW'(r_cap);
    assign cap_eff  = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
    assign cap_zero = (cap_eff == '0);

    // decision from the token leaving the last cell
    assign found   = tk_found[ENTRIES];
    assign upd_hit = upd_fire && !cap_zero && found;
    assign ins     = !cap_zero && !found && (r_put == lfu_pkg::REQ_PUT);
    assign evict   = ins && (CW'(r_occ) >= cap_eff) && tk_vhas[ENTRIES];

    // lowest free slot once the victim is gone
    always_comb begin
        if (!tk_freehas[ENTRIES]) begin
            ins_idx = tk_vidx[ENTRIES];
        end else if (evict && (tk_vidx[ENTRIES] < tk_freeidx[ENTRIES])) begin
            ins_idx = tk_vidx[ENTRIES];
        end else begin
            ins_idx = tk_freeidx[ENTRIES];
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            lfu_cell #(
                .ENTRIES   (ENTRIES),
                .COUNT_BITS(COUNT_BITS),
                .CELL_IDX  (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_key     (r_key),
                .i_found   (tk_found[g]),
                .i_fidx    (tk_fidx[g]),
                .i_fdata   (tk_fdata[g]),
                .i_frank   (tk_frank[g]),
                .i_vhas    (tk_vhas[g]),
                .i_vidx    (tk_vidx[g]),
                .i_vcnt    (tk_vcnt[g]),
                .i_vrank   (tk_vrank[g]),
                .i_freehas (tk_freehas[g]),
                .i_freeidx (tk_freeidx[g]),
                .o_found   (tk_found[g+1]),
                .o_fidx    (tk_fidx[g+1]),
                .o_fdata   (tk_fdata[g+1]),
                .o_frank   (tk_frank[g+1]),
                .o_vhas    (tk_vhas[g+1]),
                .o_vidx    (tk_vidx[g+1]),
                .o_vcnt    (tk_vcnt[g+1]),
                .o_vrank   (tk_vrank[g+1]),
                .o_freehas (tk_freehas[g+1]),
                .o_freeidx (tk_freeidx[g+1]),
                .i_upd_hit (upd_hit),
                .i_upd_ins (upd_fire && ins),
                .i_put     (r_put),
                .i_value   (r_value),
                .i_hit_idx (tk_fidx[ENTRIES]),
                .i_hit_rank(tk_frank[ENTRIES]),
                .i_evict   (evict),
                .i_vic_idx (tk_vidx[ENTRIES]),
                .i_vic_rank(tk_vrank[ENTRIES]),
                .i_ins_idx (ins_idx)
            );
        end
    endgenerate

    // sequencer: idle, walk the token across the row, then update
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_scan_cnt == IW'(ENTRIES - 1)) n_state = ST_UPD;
            end
            ST_UPD: begin
                if (can_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scan_cnt <= '0;
            r_cap      <= lfu_pkg::CAP_RESET;
            r_occ      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_scan_cnt <= '0;
            end else if (r_state == ST_SCAN) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            // an evicting insert leaves occupancy unchanged
            if (upd_fire && ins && !evict) begin
                r_occ <= r_occ + 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_put   <= i_req.req_type;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
    end

    // result register parts the request side from the result side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (upd_fire) begin
            r_out_hit     <= !cap_zero && found;
            r_out_value   <= (!cap_zero && found && (r_put == lfu_pkg::REQ_GET)) ?
                             tk_fdata[ENTRIES] : '0;
            r_out_evicted <= evict;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.evicted    = r_out_evicted;

endmodule

`default_nettype wire

/* rtl/core/lfu_cache_checker.sv */
// lfu_cache_checker: port-level assertions for lfu_cache_table
// depends on lfu_pkg; attached to the top level by the bind below
`default_nettype none

module lfu_cache_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_req_valid,
    input wire                       i_req_ready,
    input wire                       i_rsp_valid,
    input wire                       i_rsp_ready,
    input wire                       i_rsp_hit,
    input wire [lfu_pkg::DATA_W-1:0] i_rsp_value,
    input wire                       i_rsp_evicted
);

    // one request at a time: no request taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while one is in work");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_value) &&
         $stable(i_rsp_evicted)))
        else $error("result changed while stalled");

    // read data is zero unless a hit
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_hit) |-> (i_rsp_value == '0))
        else $error("read value on a miss");

    // eviction only on a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_hit && i_rsp_evicted))
        else $error("eviction on a hit");

endmodule

bind lfu_cache_table lfu_cache_checker u_lfu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_hit    (o_rsp.hit),
    .i_rsp_value  (o_rsp.read_value),
    .i_rsp_evicted(o_rsp.evicted)
);

`default_nettype wire
